// File: hw/rtl/mpmac_pkg.sv
// Shared types, codes and defaults of the multi-link MAC transmit/receive controller.
package mpmac_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam logic [15:0] BCAST_ADDR_RESET = 16'hFFFF;

    localparam logic [1:0] REG_SEND_LINK   = 2'd0;
    localparam logic [1:0] REG_OWN_ADDRESS = 2'd1;
    localparam logic [1:0] REG_BCAST_ADDR  = 2'd2;

    typedef enum logic [1:0] {
        CMD_PACKET   = 2'd0,
        CMD_TX_END   = 2'd1,
        CMD_RX_START = 2'd2,
        CMD_RX_END   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2,
        MODE_RXTX = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_DELIVER = 2'd1,
        ACT_DROP    = 2'd2,
        ACT_REFUSE  = 2'd3
    } act_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic sel_second;
        logic last_beat;
    } dp_ctrl_t;

    typedef struct packed {
        logic any_result;
        logic two_results;
    } dp_stat_t;

endpackage

// File: hw/rtl/mpmac_ctl.sv
// Sequencer of the MAC controller: accept, update, then zero, one or two result beats.
module mpmac_ctl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 strobe,
    output mpmac_pkg::dp_ctrl_t  ctrl,
    input  mpmac_pkg::dp_stat_t  stat
);
    import mpmac_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RES1 = 2'd2,
        S_RES2 = 2'd3
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   strobe_reg;
    logic   two_reg;

    assign busy   = busy_reg;
    assign strobe = strobe_reg;

    always_comb
    begin
        ctrl.load       = start && !busy_reg;
        ctrl.exec       = (state_reg == S_EXEC);
        ctrl.sel_second = (state_reg == S_RES2);
        ctrl.last_beat  = (state_reg == S_RES2) || !two_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            two_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    two_reg <= stat.two_results;
                    if (stat.any_result)
                    begin
                        state_reg  <= S_RES1;
                        strobe_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                S_RES1:
                begin
                    if (two_reg)
                    begin
                        state_reg <= S_RES2;
                    end
                    else
                    begin
                        state_reg  <= S_IDLE;
                        strobe_reg <= 1'b0;
                        busy_reg   <= 1'b0;
                    end
                end
                S_RES2:
                begin
                    state_reg  <= S_IDLE;
                    strobe_reg <= 1'b0;
                    busy_reg   <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> busy_reg)
        else $error("result beat outside a busy window");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> (busy_reg && !strobe_reg))
        else $error("accepted command did not enter update");

    a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RES2) |-> ($past(strobe_reg) && $past(two_reg)))
        else $error("second beat without a preceding first beat");

endmodule

// File: hw/rtl/mpmac_dp.sv
// Datapath of the MAC controller: config registers, handle FIFO, mode and collision state.
module mpmac_dp #(
    parameter int QUEUE_DEPTH = mpmac_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = mpmac_pkg::HANDLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpmac_pkg::dp_ctrl_t               ctrl,
    output mpmac_pkg::dp_stat_t               stat,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_addr,
    input  logic [15:0]                       cfg_data,
    input  logic [1:0]                        cmd,
    input  logic [HANDLE_BITS-1:0]            packet_handle,
    input  logic [7:0]                        source_link,
    input  logic                              frame_error,
    input  logic [15:0]                       dest_address,
    output logic [1:0]                        action,
    output logic [HANDLE_BITS-1:0]            out_handle,
    output logic [7:0]                        tx_link,
    output logic [1:0]                        mode_after,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  queue_level,
    output logic [15:0]                       collision_count,
    output logic                              last
);
    import mpmac_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [15:0]      COLL_MAX = 16'hFFFF;

    logic [HANDLE_BITS-1:0] mem [QUEUE_DEPTH];

    logic [7:0]       send_link_reg;
    logic [15:0]      own_addr_reg;
    logic [15:0]      bcast_reg;
    mode_t            mode_reg;
    logic [7:0]       rx_link_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [15:0]      coll_reg;

    cmd_t                   cmd_q_reg;
    logic [HANDLE_BITS-1:0] handle_q_reg;
    logic [7:0]             src_q_reg;
    logic                   ferr_q_reg;
    logic [15:0]            dest_q_reg;
    act_t                   act0_reg;
    logic                   bypass_reg;
    logic [HANDLE_BITS-1:0] mem_rd_reg;

    logic             push;
    logic             refuse;
    logic             drop;
    logic             good_rx;
    logic             good_rxtx;
    logic             bad;
    logic             try_send;
    logic             send;
    logic             collide;
    mode_t            mode_sent;
    mode_t            mode_unsent;
    mode_t            mode_next;
    act_t             act0;
    logic [CNT_W-1:0] count_next;
    logic             differs;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        differs   = (rx_link_reg != send_link_reg);
        push      = (cmd_q_reg == CMD_PACKET) && (count_reg != DEPTH_C);
        refuse    = (cmd_q_reg == CMD_PACKET) && (count_reg == DEPTH_C);
        bad       = ferr_q_reg || (src_q_reg != rx_link_reg) ||
                    ((dest_q_reg != own_addr_reg) && (dest_q_reg != bcast_reg));
        drop      = (cmd_q_reg == CMD_RX_END) && bad;
        good_rx   = (cmd_q_reg == CMD_RX_END) && !bad && (mode_reg == MODE_RX);
        good_rxtx = (cmd_q_reg == CMD_RX_END) && !bad && (mode_reg == MODE_RXTX);
        collide   = (cmd_q_reg == CMD_RX_START) && (mode_reg == MODE_TX) &&
                    (src_q_reg == send_link_reg);

        try_send    = 1'b0;
        mode_sent   = mode_reg;
        mode_unsent = mode_reg;
        case (cmd_q_reg)
            CMD_PACKET:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    try_send    = 1'b1;
                    mode_sent   = MODE_TX;
                    mode_unsent = MODE_IDLE;
                end
                else if ((mode_reg == MODE_RX) && differs)
                begin
                    try_send    = 1'b1;
                    mode_sent   = MODE_RXTX;
                    mode_unsent = MODE_RX;
                end
            end
            CMD_TX_END:
            begin
                if (mode_reg == MODE_TX)
                begin
                    try_send    = 1'b1;
                    mode_sent   = MODE_TX;
                    mode_unsent = MODE_IDLE;
                end
                else if ((mode_reg == MODE_RXTX) && differs)
                begin
                    try_send    = 1'b1;
                    mode_sent   = MODE_RXTX;
                    mode_unsent = MODE_RX;
                end
            end
            CMD_RX_END:
            begin
                if (good_rx)
                begin
                    try_send    = 1'b1;
                    mode_sent   = MODE_TX;
                    mode_unsent = MODE_IDLE;
                end
            end
            default:
            begin
                try_send = 1'b0;
            end
        endcase

        send = try_send && ((count_reg != '0) || push);

        if (cmd_q_reg == CMD_RX_START)
        begin
            if (mode_reg == MODE_IDLE)
                mode_next = MODE_RX;
            else if (mode_reg == MODE_TX)
                mode_next = (src_q_reg != send_link_reg) ? MODE_RXTX : MODE_IDLE;
            else
                mode_next = mode_reg;
        end
        else if (good_rxtx)
            mode_next = MODE_TX;
        else if (try_send)
            mode_next = send ? mode_sent : mode_unsent;
        else
            mode_next = mode_reg;

        count_next = count_reg + CNT_W'(push) - CNT_W'(send);

        if (refuse)
            act0 = ACT_REFUSE;
        else if (drop)
            act0 = ACT_DROP;
        else if (good_rx || good_rxtx)
            act0 = ACT_DELIVER;
        else
            act0 = ACT_SEND;

        stat.any_result  = refuse || drop || good_rx || good_rxtx || send;
        stat.two_results = (refuse || good_rx || good_rxtx) && send;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_link_reg <= '0;
            own_addr_reg  <= '0;
            bcast_reg     <= BCAST_ADDR_RESET;
            mode_reg      <= MODE_IDLE;
            rx_link_reg   <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            coll_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    REG_SEND_LINK:   send_link_reg <= cfg_data[7:0];
                    REG_OWN_ADDRESS: own_addr_reg  <= cfg_data;
                    REG_BCAST_ADDR:  bcast_reg     <= cfg_data;
                    default:         ;
                endcase
            end
            if (ctrl.exec)
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                if (push)
                    wr_ptr_reg <= ptr_inc(wr_ptr_reg);
                if (send)
                    rd_ptr_reg <= ptr_inc(rd_ptr_reg);
                if (cmd_q_reg == CMD_RX_START)
                    rx_link_reg <= src_q_reg;
                if (collide && (coll_reg != COLL_MAX))
                    coll_reg <= coll_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_q_reg    <= cmd_t'(cmd);
            handle_q_reg <= packet_handle;
            src_q_reg    <= source_link;
            ferr_q_reg   <= frame_error;
            dest_q_reg   <= dest_address;
        end
        if (ctrl.exec)
        begin
            if (push)
                mem[wr_ptr_reg] <= handle_q_reg;
            mem_rd_reg <= mem[rd_ptr_reg];
            bypass_reg <= (count_reg == '0);
            act0_reg   <= act0;
        end
    end

    logic                   send_beat;
    logic [HANDLE_BITS-1:0] head;

    always_comb
    begin
        head            = bypass_reg ? handle_q_reg : mem_rd_reg;
        send_beat       = ctrl.sel_second || (act0_reg == ACT_SEND);
        action          = ctrl.sel_second ? ACT_SEND : act0_reg;
        out_handle      = send_beat ? head : handle_q_reg;
        tx_link         = send_beat ? send_link_reg : 8'd0;
        mode_after      = mode_reg;
        queue_level     = count_reg;
        collision_count = coll_reg;
        last            = ctrl.last_beat;
    end

endmodule

// File: hw/rtl/multi_phy_mac_tx_rx_controller.sv
// Top level of the multi-link MAC transmit/receive controller.
//
// Usage: drive cmd and its fields with start high while busy is low; that edge takes
// the event. Events: queue an outgoing packet handle, transmit ended, receive
// started on a link, receive ended (with error flag, link and destination).
// Results come out as beats marked by strobe, each present for exactly one cycle,
// with last set on the final beat of the event; there is no back-pressure.
// An event yields zero, one or two beats (refuse or deliver, then start transmit).
// Sequence: the cycle after the accepting edge updates state and reads the FIFO head
// from its registered memory port; beats follow one per cycle. An event holds busy
// through its update and its beats, so a new event is taken only after its last beat.
// mode_after, queue_level and collision_count show the state after the whole event.
// Config: cfg_wr_en writes cfg_data into register cfg_addr (0 send link, 1 own
// address, 2 broadcast address); index 3 is ignored. Write only while busy is low.
// Reset clears mode, FIFO pointers and count, collision counter, receive link and
// config (broadcast address to all ones); FIFO storage is not cleared.
module multi_phy_mac_tx_rx_controller #(
    parameter int QUEUE_DEPTH = mpmac_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = mpmac_pkg::HANDLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_addr,
    input  logic [15:0]                       cfg_data,
    input  logic [1:0]                        cmd,
    input  logic [HANDLE_BITS-1:0]            packet_handle,
    input  logic [7:0]                        source_link,
    input  logic                              frame_error,
    input  logic [15:0]                       dest_address,
    output logic                              strobe,
    output logic [1:0]                        action,
    output logic [HANDLE_BITS-1:0]            out_handle,
    output logic [7:0]                        tx_link,
    output logic [1:0]                        mode_after,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  queue_level,
    output logic [15:0]                       collision_count,
    output logic                              last
);
    import mpmac_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    mpmac_ctl u_ctl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .strobe (strobe),
        .ctrl   (ctrl),
        .stat   (stat)
    );

    mpmac_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .packet_handle   (packet_handle),
        .source_link     (source_link),
        .frame_error     (frame_error),
        .dest_address    (dest_address),
        .action          (action),
        .out_handle      (out_handle),
        .tx_link         (tx_link),
        .mode_after      (mode_after),
        .queue_level     (queue_level),
        .collision_count (collision_count),
        .last            (last)
    );

endmodule
